### hw/rtl/ffla_pkg.sv
// ----------------------------------------------------------------------------
// ffla_pkg
// Shared sizes, types and register codes of the first-fit lane assigner.
// ----------------------------------------------------------------------------
package ffla_pkg;

    // Lane storage and time width
    localparam int MAX_LANES  = 64;
    localparam int TIME_BITS  = 48;

    // Derived widths: lane index, open-lane count, limit compare
    localparam int IDX_W      = $clog2(MAX_LANES);
    localparam int CNT_W      = $clog2(MAX_LANES + 1);
    localparam int LIMIT_BITS = 7;
    localparam int LIM_W      = (CNT_W > LIMIT_BITS) ? CNT_W : LIMIT_BITS;
    localparam int LANE_BITS  = 6;

    // Register file
    localparam int          ADDR_W         = 3;
    localparam logic [0:0]  REG_LANE_LIMIT = 1'b0;
    localparam logic [LIMIT_BITS-1:0] LIMIT_RESET = 7'd64;

    // One interval as seen by the lanes; start_time sits in the lowest bits,
    // matching the input word layout
    typedef struct packed {
        logic [TIME_BITS-1:0] close_end;
        logic [TIME_BITS-1:0] close_start;
        logic [TIME_BITS-1:0] end_time;
        logic [TIME_BITS-1:0] start_time;
    } t_item;

    // Placement command broadcast to the row (open or forced lane)
    typedef struct packed {
        logic             we;
        logic             cond;   // write only if the interval ends later
        logic [IDX_W-1:0] idx;
    } t_cmd;

    // Search status gathered from the row
    typedef struct packed {
        logic hit;    // token found a fitting lane this cycle
        logic stop;   // token ran past the open lanes
    } t_scan;

endpackage

### hw/rtl/ffla_cell.sv
// ----------------------------------------------------------------------------
// ffla_cell
// One lane: holds its occupant and checks the passing search token.
// ----------------------------------------------------------------------------
module ffla_cell
    import ffla_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_tok,      // token from left neighbor
    input  logic  i_is_open,  // lane lies below the open-lane count
    input  t_item i_item,     // interval under placement
    input  logic  i_sel,      // placement command aims at this lane
    input  logic  i_cond,     // placement only if interval ends later
    output logic  o_tok,      // token to right neighbor
    output logic  o_hit,
    output logic  o_stop
);

    logic                 r_tok;
    logic [TIME_BITS-1:0] r_end;
    logic [TIME_BITS-1:0] r_cs;
    logic [TIME_BITS-1:0] r_ce;
    logic                 fit;
    logic                 wr;

    // Occupant ends in time and its close span does not overlap
    assign fit = (i_item.start_time >= r_end) &&
                 ((i_item.start_time >= r_ce) || (i_item.end_time <= r_cs));

    assign o_hit  = r_tok & i_is_open & fit;
    assign o_tok  = r_tok & i_is_open & ~fit;
    assign o_stop = r_tok & ~i_is_open;

    assign wr = o_hit | (i_sel & (~i_cond | (i_item.end_time > r_end)));

    // Token moves one lane per cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tok <= 1'b0;
        end else begin
            r_tok <= i_tok;
        end
    end

    // Occupant storage
    always_ff @(posedge i_clk) begin
        if (wr) begin
            r_end <= i_item.end_time;
            r_cs  <= i_item.close_start;
            r_ce  <= i_item.close_end;
        end
    end

endmodule

### hw/rtl/ffla_row.sv
// ----------------------------------------------------------------------------
// ffla_row
// Row of lane cells; the search token walks from lane 0 upward.
// ----------------------------------------------------------------------------
module ffla_row
    import ffla_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,   // inject token into lane 0
    input  logic [CNT_W-1:0] i_count,   // open lanes
    input  t_item            i_item,
    input  t_cmd             i_cmd,
    output t_scan            o_scan
);

    logic [MAX_LANES-1:0] tok;
    logic [MAX_LANES-1:0] hit;
    logic [MAX_LANES-1:0] stop;

    for (genvar k = 0; k < MAX_LANES; k++) begin : g_lane
        logic tok_in;
        logic is_open;
        logic sel;

        if (k == 0) begin : g_head
            assign tok_in = i_start;
        end else begin : g_body
            assign tok_in = tok[k-1];
        end

        assign is_open = CNT_W'(k) < i_count;
        assign sel     = i_cmd.we && (i_cmd.idx == IDX_W'(k));

        ffla_cell u_cell (
            .i_clk     (i_clk),
            .i_rst_n   (i_rst_n),
            .i_tok     (tok_in),
            .i_is_open (is_open),
            .i_item    (i_item),
            .i_sel     (sel),
            .i_cond    (i_cmd.cond),
            .o_tok     (tok[k]),
            .o_hit     (hit[k]),
            .o_stop    (stop[k])
        );
    end

    // Token falling off the last lane also ends the search
    assign o_scan.hit  = |hit;
    assign o_scan.stop = (|stop) | tok[MAX_LANES-1];

endmodule

### hw/rtl/first_fit_interval_lane_assigner.sv
// ----------------------------------------------------------------------------
// first_fit_interval_lane_assigner
// Places sorted intervals on the lowest free lane, opening lanes up to a
// configured limit and forcing overflow onto the highest open lane.
// ----------------------------------------------------------------------------
//  Channel  Dir  Handshake          Payload
//  s        in   tvalid/tready      tdata: start,end,close_start,close_end
//                                   tuser: first_of_pass
//  m        out  tvalid/tready      tdata: lane; tuser: opened_lane,over_limit
//  cfg      in   APB, pready = 1    reg 0 @ 0x0: lane_limit
//
//  One word at a time: accept, then the token walks one lane per cycle.
//  The token walk along the row sets how long a word takes: up to lane j
//  for a word placed on lane j, past all open lanes for a word that opens
//  or is forced.
//  A waiting result holds the next placement; the next word is accepted
//  as soon as the previous one has left the row.
//  Reset empties all lanes and sets lane_limit to 64; no clearing pass.
// ----------------------------------------------------------------------------
module first_fit_interval_lane_assigner
    import ffla_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    // Interval stream
    input  logic                   i_s_tvalid,
    output logic                   o_s_tready,
    input  logic [4*TIME_BITS-1:0] i_s_tdata,   // start_time, end_time, close_start, close_end
    input  logic [0:0]             i_s_tuser,   // first_of_pass
    // Result stream
    output logic                   o_m_tvalid,
    input  logic                   i_m_tready,
    output logic [7:0]             o_m_tdata,   // lane, 2'b0
    output logic [1:0]             o_m_tuser,   // opened_lane, over_limit
    // Register port
    input  logic                   psel,
    input  logic                   penable,
    input  logic                   pwrite,
    input  logic [ADDR_W-1:0]      paddr,
    input  logic [31:0]            pwdata,
    output logic [31:0]            prdata,
    output logic                   pready
);

    typedef enum logic [1:0] {S_IDLE, S_SCAN, S_OUT} t_state;

    t_state                r_state;
    t_item                 r_item;
    t_cmd                  r_cmd;
    t_scan                 scan;
    logic [CNT_W-1:0]      r_count;
    logic [IDX_W-1:0]      r_pos;
    logic [IDX_W-1:0]      r_res_lane;
    logic                  r_res_opened;
    logic                  r_res_over;
    logic                  r_out_vld;
    logic [LANE_BITS-1:0]  r_out_lane;
    logic                  r_out_opened;
    logic                  r_out_over;
    logic [LIMIT_BITS-1:0] r_lane_limit;
    logic                  s_acc;
    logic                  cfg_wr;
    logic [LIM_W-1:0]      lim_ext;
    logic [LIM_W-1:0]      eff_lim;
    logic                  can_open;

    // Register port
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && (paddr[2] == REG_LANE_LIMIT);
    assign prdata = (paddr[2] == REG_LANE_LIMIT) ? {25'd0, r_lane_limit} : 32'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lane_limit <= LIMIT_RESET;
        end else if (cfg_wr) begin
            r_lane_limit <= pwdata[LIMIT_BITS-1:0];
        end
    end

    // Effective limit: zero acts as one, clamp to lane capacity
    assign lim_ext = LIM_W'(r_lane_limit);
    always_comb begin
        eff_lim = lim_ext;
        if (lim_ext == '0) begin
            eff_lim = LIM_W'(1);
        end else if (lim_ext > LIM_W'(MAX_LANES)) begin
            eff_lim = LIM_W'(MAX_LANES);
        end
    end
    assign can_open = LIM_W'(r_count) < eff_lim;

    assign o_s_tready = (r_state == S_IDLE);
    assign s_acc      = i_s_tvalid && o_s_tready;

    // Lane row
    ffla_row u_row (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (s_acc),
        .i_count (r_count),
        .i_item  (r_item),
        .i_cmd   (r_cmd),
        .o_scan  (scan)
    );

    // Sequencer and output word
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_count   <= '0;
            r_cmd     <= '0;
            r_out_vld <= 1'b0;
        end else begin
            // placement command is a one-cycle strobe, raised after the search misses
            r_cmd.we <= (r_state == S_SCAN) && !scan.hit && scan.stop;
            if (r_out_vld && i_m_tready && (r_state != S_OUT)) begin
                r_out_vld <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (s_acc) begin
                        r_item  <= i_s_tdata;
                        r_pos   <= '0;
                        if (i_s_tuser[0]) begin
                            r_count <= '0;
                        end
                        r_state <= S_SCAN;
                    end
                end
                S_SCAN: begin
                    r_pos <= r_pos + 1'b1;
                    if (scan.hit) begin
                        r_res_lane   <= r_pos;
                        r_res_opened <= 1'b0;
                        r_res_over   <= 1'b0;
                        r_state      <= S_OUT;
                    end else if (scan.stop) begin
                        if (can_open) begin
                            r_cmd.cond   <= 1'b0;
                            r_cmd.idx    <= IDX_W'(r_count);
                            r_res_lane   <= IDX_W'(r_count);
                            r_res_opened <= 1'b1;
                            r_res_over   <= 1'b0;
                            r_count      <= r_count + 1'b1;
                        end else begin
                            r_cmd.cond   <= 1'b1;
                            r_cmd.idx    <= IDX_W'(r_count - 1'b1);
                            r_res_lane   <= IDX_W'(r_count - 1'b1);
                            r_res_opened <= 1'b0;
                            r_res_over   <= 1'b1;
                        end
                        r_state <= S_OUT;
                    end
                end
                S_OUT: begin
                    if (!r_out_vld || i_m_tready) begin
                        r_out_vld    <= 1'b1;
                        r_out_lane   <= LANE_BITS'(r_res_lane);
                        r_out_opened <= r_res_opened;
                        r_out_over   <= r_res_over;
                        r_state      <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_m_tvalid = r_out_vld;
    assign o_m_tdata  = {2'b00, r_out_lane};
    assign o_m_tuser  = {r_out_over, r_out_opened};

    // Checks
    a_hit_stop_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(scan.hit && scan.stop))
        else $error("row reports a hit and a miss together");

    a_cmd_in_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cmd.we |-> (r_state == S_OUT))
        else $error("placement command outside output state");

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(MAX_LANES))
        else $error("open-lane count beyond capacity");

    a_pass_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_acc && i_s_tuser[0]) |=> (r_count == '0))
        else $error("new pass did not empty the lanes");

endmodule

### tb/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Checks the first-fit lane assigner word by word against a behavioral
// predictor: directed edge cases for fields and lane limits, then random
// sorted layouts with noise, random idling on both streams, and one long
// result-side hold-off that backs the block up into its input.
// ----------------------------------------------------------------------------
module testbench;
    import ffla_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    typedef logic [TIME_BITS-1:0] t_ticks;

    // One expected placement
    typedef struct packed {
        logic [LANE_BITS-1:0] lane;
        logic                 opened;
        logic                 forced;
    } t_placement;

    localparam logic [ADDR_W-1:0] LIMIT_ADDR = ADDR_W'(4 * REG_LANE_LIMIT);
    localparam t_ticks            TICKS_MAX  = '1;

    // DUT signals
    logic                   i_clk = 1'b0;
    logic                   i_rst_n;
    logic                   i_s_tvalid;
    logic                   o_s_tready;
    logic [4*TIME_BITS-1:0] i_s_tdata;   // start_time, end_time, close_start, close_end
    logic [0:0]             i_s_tuser;   // first_of_pass
    logic                   o_m_tvalid;
    logic                   i_m_tready;
    logic [7:0]             o_m_tdata;   // lane, 2'b0
    logic [1:0]             o_m_tuser;   // opened_lane, over_limit
    logic                   psel;
    logic                   penable;
    logic                   pwrite;
    logic [ADDR_W-1:0]      paddr;
    logic [31:0]            pwdata;
    logic [31:0]            prdata;
    logic                   pready;

    first_fit_interval_lane_assigner u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready)
    );

    always #10 i_clk = ~i_clk;

    // Lane occupants and counters mirrored from the block
    t_ticks          occ_end   [MAX_LANES];
    t_ticks          occ_cs    [MAX_LANES];
    t_ticks          occ_ce    [MAX_LANES];
    int              lanes_open = 0;
    logic [6:0]      limit_reg  = LIMIT_RESET;

    t_placement      pending_placements[$];

    int              errors          = 0;
    int              items_sent      = 0;
    int              results_checked = 0;
    int              lanes_opened    = 0;
    int              forced_placed   = 0;
    int              peak_open       = 0;
    int              limit_writes    = 0;

    bit              tx_idle   = 1'b1;
    bit              rx_idle   = 1'b1;
    int              hold_req  = 0;

    // Random layout generator state
    int              pass_left = 0;
    t_ticks          cur_t     = '0;
    int unsigned     step_max  = 0;
    int unsigned     dur_max   = 0;

    task automatic report_mismatch(input string msg);
        $display("MISMATCH @%0t: %s", $realtime, msg);
        errors++;
    endtask

    function automatic t_ticks rand_ticks();
        logic [63:0] r;
        r = {$urandom(), $urandom()};
        return r[TIME_BITS-1:0];
    endfunction

    // First-fit placement of one interval; updates the mirrored lanes
    function automatic t_placement place_interval(input bit first, input t_ticks s,
                                                  input t_ticks e, input t_ticks cs,
                                                  input t_ticks ce);
        t_placement p;
        int         lim;
        int         k;
        int         hit;
        lim = limit_reg;
        if (lim == 0) lim = 1;
        if (lim > MAX_LANES) lim = MAX_LANES;
        if (first) lanes_open = 0;
        hit = -1;
        for (k = 0; k < lanes_open; k++) begin
            if (hit < 0 && s >= occ_end[k] && (s >= occ_ce[k] || e <= occ_cs[k]))
                hit = k;
        end
        p = '0;
        if (hit >= 0) begin
            p.lane = hit[LANE_BITS-1:0];
            occ_end[hit] = e; occ_cs[hit] = cs; occ_ce[hit] = ce;
        end else if (lanes_open < lim) begin
            p.lane   = lanes_open[LANE_BITS-1:0];
            p.opened = 1'b1;
            occ_end[lanes_open] = e; occ_cs[lanes_open] = cs; occ_ce[lanes_open] = ce;
            lanes_open++;
            lanes_opened++;
            if (lanes_open > peak_open) peak_open = lanes_open;
        end else begin
            // forced onto the highest open lane, replaced only by a later end
            k        = lanes_open - 1;
            p.lane   = k[LANE_BITS-1:0];
            p.forced = 1'b1;
            forced_placed++;
            if (e > occ_end[k]) begin
                occ_end[k] = e; occ_cs[k] = cs; occ_ce[k] = ce;
            end
        end
        return p;
    endfunction

    // Offer one interval word and record its placement once accepted
    task automatic send_interval(input bit first, input t_ticks s, input t_ticks e,
                                 input t_ticks cs, input t_ticks ce);
        int gap;
        gap = tx_idle ? $urandom_range(0, 5) : 0;
        if (gap > 0) begin
            i_s_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= {ce, cs, e, s};
        i_s_tuser  <= first;
        do @(posedge i_clk); while (!o_s_tready);
        pending_placements.push_back(place_interval(first, s, e, cs, ce));
        items_sent++;
    endtask

    // Stop offering and wait for every pending placement
    task automatic drain();
        i_s_tvalid <= 1'b0;
        while (pending_placements.size() != 0) @(posedge i_clk);
    endtask

    // APB write of lane_limit, then read back
    task automatic write_lane_limit(input logic [6:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= LIMIT_ADDR;
        pwdata  <= {25'd0, value};
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        limit_reg = value;
        limit_writes++;
        // straight into the read setup, psel stays high
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        if (prdata[6:0] !== value)
            report_mismatch($sformatf("lane_limit read %0d, wrote %0d", prdata[6:0], value));
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // One random interval: mostly sorted passes, some noise
    task automatic random_interval();
        bit     first;
        t_ticks s, e, cs, ce;
        if ($urandom_range(0, 9) == 0) begin
            first = ($urandom_range(0, 7) == 0);
            s  = rand_ticks();
            e  = rand_ticks();
            cs = rand_ticks();
            ce = rand_ticks();
        end else begin
            if (pass_left == 0) begin
                pass_left = $urandom_range(4, 90);
                first     = 1'b1;
                cur_t     = ($urandom_range(0, 3) == 0) ? rand_ticks()
                                                       : t_ticks'($urandom_range(0, 1000));
                case ($urandom_range(0, 2))
                    0: step_max = 2;
                    1: step_max = 30;
                    default: step_max = 500;
                endcase
                case ($urandom_range(0, 3))
                    0: dur_max = 10;
                    1: dur_max = 200;
                    2: dur_max = 5000;
                    default: dur_max = 40000;
                endcase
            end else begin
                first = 1'b0;
            end
            pass_left--;
            cur_t = cur_t + t_ticks'($urandom_range(0, step_max));
            s = cur_t;
            e = s + t_ticks'($urandom_range(0, dur_max));
            case ($urandom_range(0, 3))
                0: begin cs = e; ce = e + t_ticks'($urandom_range(0, 50)); end
                1: begin
                    cs = e + t_ticks'($urandom_range(0, dur_max));
                    ce = cs + t_ticks'($urandom_range(0, dur_max));
                end
                2: begin cs = '0; ce = '0; end
                default: begin cs = s - t_ticks'($urandom_range(0, 40)); ce = s; end
            endcase
        end
        send_interval(first, s, e, cs, ce);
    endtask

    // Field extremes, close-span overlap, inverted spans, unsorted starts
    task automatic test_directed_fields();
        send_interval(1'b1, '0, '0, '0, '0);
        send_interval(1'b0, '0, TICKS_MAX, TICKS_MAX, TICKS_MAX);
        send_interval(1'b0, 48'd1, 48'd2, 48'd3, 48'd4);
        send_interval(1'b0, 48'd5, 48'd9, 48'd10, 48'd12);
        // lane 1 free by end but its close span overlaps
        send_interval(1'b0, 48'd10, 48'd11, 48'd20, 48'd21);
        // ends before the occupant's close span; inverted main and close spans
        send_interval(1'b0, 48'd11, 48'd10, 48'd15, 48'd14);
        // start earlier than the previous one
        send_interval(1'b0, 48'd3, 48'd4, '0, '0);
        send_interval(1'b0, TICKS_MAX, TICKS_MAX, TICKS_MAX, TICKS_MAX);
        send_interval(1'b1, TICKS_MAX, '0, '0, TICKS_MAX);
        drain();
    endtask

    // Limit of zero, limits above capacity, forced placement with and without replace
    task automatic test_limit_extremes();
        write_lane_limit(7'd0);
        send_interval(1'b1, 48'd0, 48'd10, '0, '0);
        send_interval(1'b0, 48'd1, 48'd20, '0, '0);
        send_interval(1'b0, 48'd2, 48'd5, '0, '0);
        drain();
        write_lane_limit(7'd127);
        send_interval(1'b1, 48'd7, 48'd9, 48'd9, 48'd11);
        drain();
        write_lane_limit(7'd65);
        send_interval(1'b0, 48'd8, 48'd9, '0, '0);
        drain();
        write_lane_limit(7'd3);
        send_interval(1'b1, 48'd0, 48'd100, '0, '0);
        send_interval(1'b0, 48'd1, 48'd101, '0, '0);
        send_interval(1'b0, 48'd2, 48'd102, '0, '0);
        send_interval(1'b0, 48'd3, 48'd200, '0, '0);
        send_interval(1'b0, 48'd4, 48'd50, '0, '0);
        drain();
    endtask

    // Limit dropped below the open lane count in the middle of a pass
    task automatic test_limit_lowered();
        write_lane_limit(7'd1);
        send_interval(1'b0, 48'd5, 48'd300, '0, '0);
        send_interval(1'b0, 48'd6, 48'd250, '0, '0);
        send_interval(1'b0, 48'd400, 48'd500, '0, '0);
        drain();
    endtask

    // Random layouts under a series of limits
    task automatic test_random_layouts();
        logic [6:0] limits[8];
        int         i;
        limits = '{7'd64, 7'd1, 7'd2, 7'd127, 7'd0, 7'd65, 7'd0, 7'd0};
        limits[6] = 7'($urandom_range(4, 63));
        limits[7] = 7'($urandom_range(1, 127));
        for (i = 0; i < 8; i++) begin
            drain();
            write_lane_limit(limits[i]);
            // one phase runs both streams flat out
            tx_idle = (i != 3);
            rx_idle = (i != 3);
            repeat (115) random_interval();
        end
        tx_idle = 1'b1;
        rx_idle = 1'b1;
        drain();
    endtask

    // Long hold-off on results while words keep coming, then a full pause
    task automatic test_backpressure();
        write_lane_limit(7'd64);
        tx_idle  = 1'b0;
        hold_req = 300;
        repeat (40) random_interval();
        tx_idle  = 1'b1;
        drain();
    endtask

    // Result-side ready: random stalls, plus a requested long hold-off
    initial begin : result_ready
        int stall;
        int n;
        wait (i_rst_n === 1'b1);
        @(posedge i_clk);
        forever begin
            if (hold_req > 0) begin
                n        = hold_req;
                hold_req = 0;
                i_m_tready <= 1'b0;
                repeat (n) @(posedge i_clk);
            end
            stall = rx_idle ? $urandom_range(0, 5) : 0;
            if (stall > 0) begin
                i_m_tready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            i_m_tready <= 1'b1;
            do @(posedge i_clk); while (!o_m_tvalid);
        end
    end

    // Compare each accepted result word with the oldest pending placement
    always @(posedge i_clk) begin : result_check
        t_placement want;
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            if (pending_placements.size() == 0) begin
                report_mismatch($sformatf("result lane %0d with nothing pending",
                                          o_m_tdata[5:0]));
            end else begin
                want = pending_placements.pop_front();
                results_checked++;
                if (o_m_tdata[5:0] !== want.lane)
                    report_mismatch($sformatf("lane %0d, want %0d", o_m_tdata[5:0], want.lane));
                if (o_m_tdata[7:6] !== 2'b00)
                    report_mismatch($sformatf("tdata pad bits %b", o_m_tdata[7:6]));
                if (o_m_tuser[0] !== want.opened)
                    report_mismatch($sformatf("opened_lane %b, want %b (lane %0d)",
                                              o_m_tuser[0], want.opened, want.lane));
                if (o_m_tuser[1] !== want.forced)
                    report_mismatch($sformatf("over_limit %b, want %b (lane %0d)",
                                              o_m_tuser[1], want.forced, want.lane));
            end
        end
    end

    // Run limit
    initial begin : watchdog
        #(10_000_000);
        $display("timeout with %0d placements pending", pending_placements.size());
        $display("testbench: errors");
        $finish;
    end

    // Main sequence
    initial begin : main_seq
        i_rst_n    <= 1'b0;
        i_s_tvalid <= 1'b0;
        i_s_tdata  <= '0;
        i_s_tuser  <= '0;
        i_m_tready <= 1'b0;
        psel       <= 1'b0;
        penable    <= 1'b0;
        pwrite     <= 1'b0;
        paddr      <= '0;
        pwdata     <= '0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed_fields();
        test_limit_extremes();
        test_limit_lowered();
        test_random_layouts();
        test_backpressure();

        drain();
        repeat (80) @(posedge i_clk);
        if (pending_placements.size() != 0)
            report_mismatch($sformatf("%0d placements never arrived",
                                      pending_placements.size()));

        $display("placed %0d intervals, %0d results checked, %0d limit writes",
                 items_sent, results_checked, limit_writes);
        $display("lanes opened %0d times, %0d forced placements, peak of %0d open lanes",
                 lanes_opened, forced_placed, peak_open);
        if (errors == 0) begin
            $display("testbench: clean");
        end else begin
            $display("testbench: errors");
        end
        $finish;
    end

endmodule
